>>> rtl/core/tccw_pkg.sv
package tccw_pkg;

    // Fixed field widths of the request and result items.
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int BYTE_W = 8;
    localparam int CELL_W = 16;

    // Request actions.
    localparam logic [1:0] ACT_PUT_CURSOR = 2'd0;
    localparam logic [1:0] ACT_PUT_AT     = 2'd1;
    localparam logic [1:0] ACT_READ       = 2'd2;
    localparam logic [1:0] ACT_CLEAR      = 2'd3;

    // Character codes with a special meaning.
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_ERROR   = 8'h45;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;

    // Configuration registers.
    localparam logic        REG_DEFAULT_ATTR = 1'b0;
    localparam logic        REG_ERROR_ATTR   = 1'b1;
    localparam logic [7:0]  DEFAULT_ATTR_RST = 8'd15;
    localparam logic [7:0]  ERROR_ATTR_RST   = 8'd244;

    // Datapath operations selected by the controller.
    localparam logic [2:0] OP_ITEM   = 3'd0;
    localparam logic [2:0] OP_EXEC   = 3'd1;
    localparam logic [2:0] OP_INIT   = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_SCROLL = 3'd4;

    typedef struct packed {
        logic [1:0]        action;
        logic [BYTE_W-1:0] char_code;
        logic [BYTE_W-1:0] attribute;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
    } t_in_item;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [BYTE_W-1:0] read_char;
        logic [BYTE_W-1:0] read_attr;
        logic              position_error;
    } t_out_item;

    typedef struct packed {
        logic [2:0] op;
        logic       cap_item;
        logic       cnt_run;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       scroll;
        logic       cnt_last;
    } t_sts;

endpackage

>>> rtl/core/tccw_ram.sv
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/tccw_ctrl.sv
module tccw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  tccw_pkg::t_sts i_sts,
    output tccw_pkg::t_cmd o_cmd
);

    import tccw_pkg::*;

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_CLEAR  = 3'd3;
    localparam logic [2:0] S_SCROLL = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;
    t_cmd       cmd;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        cmd          = '0;
        cmd.op       = OP_ITEM;
        case (r_state)
            S_INIT: begin
                cmd.op      = OP_INIT;
                cmd.cnt_run = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.cap_item = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.op = OP_EXEC;
                if (i_sts.action == ACT_CLEAR) begin
                    n_state = S_CLEAR;
                end else if (i_sts.scroll) begin
                    n_state = S_SCROLL;
                end else if (i_sts.action == ACT_READ) begin
                    n_state = S_RESULT;
                end else if (out_free) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_CLEAR: begin
                cmd.op      = OP_CLEAR;
                cmd.cnt_run = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_RESULT;
                end
            end
            S_SCROLL: begin
                cmd.op      = OP_SCROLL;
                cmd.cnt_run = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

>>> rtl/core/tccw_dpath.sv
module tccw_dpath #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tccw_pkg::t_cmd      i_cmd,
    input  tccw_pkg::t_in_item  i_in_item,
    input  logic [7:0]          i_default_attr,
    input  logic [7:0]          i_error_attr,
    output tccw_pkg::t_sts      o_sts,
    output tccw_pkg::t_out_item o_out_item
);

    import tccw_pkg::*;

    localparam int CELLS = COLS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CNT_W = $clog2(CELLS + 1);

    localparam logic [AW-1:0]    COLS_A    = AW'(COLS);
    localparam logic [AW-1:0]    LAST_CELL = AW'(CELLS - 1);
    localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [COL_W:0]   COLS_CMP  = (COL_W + 1)'(COLS);
    localparam logic [ROW_W:0]   ROWS_CMP  = (ROW_W + 1)'(ROWS);
    localparam logic [CNT_W:0]   COLS_S    = (CNT_W + 1)'(COLS);
    localparam logic [CNT_W:0]   CELLS_S   = (CNT_W + 1)'(CELLS);
    localparam logic [CNT_W-1:0] KEEP_C    = CNT_W'(CELLS - COLS);
    localparam logic [CNT_W-1:0] LAST_C    = CNT_W'(CELLS - 1);
    localparam logic [CNT_W-1:0] END_C     = CNT_W'(CELLS);

    t_in_item          r_item;
    t_out_item         r_out;
    logic [COL_W-1:0]  r_ccol;
    logic [COL_W-1:0]  n_ccol;
    logic [ROW_W-1:0]  r_crow;
    logic [ROW_W-1:0]  n_crow;
    logic [CNT_W-1:0]  r_cnt;

    logic [BYTE_W-1:0] at_eff;
    logic              bad;
    logic              is_nl;
    logic [COL_W-1:0]  sel_col;
    logic [ROW_W-1:0]  sel_row;
    logic [AW-1:0]     pos;
    logic              wrap_col;
    logic              last_row;
    logic              adv;
    logic              bad_put;
    logic [COL_W-1:0]  adv_col;
    logic [ROW_W-1:0]  adv_row;
    logic [CNT_W:0]    src_sum;
    logic              cnt_last;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    // Decode of the captured request.
    assign at_eff   = (r_item.attribute == '0) ? i_default_attr : r_item.attribute;
    assign bad      = ({1'b0, r_item.col} >= COLS_CMP) || ({1'b0, r_item.row} >= ROWS_CMP);
    assign is_nl    = (r_item.char_code == CH_NEWLINE);
    assign sel_col  = (r_item.action == ACT_PUT_CURSOR) ? r_ccol : r_item.col;
    assign sel_row  = (r_item.action == ACT_PUT_CURSOR) ? r_crow : r_item.row;
    assign pos      = AW'(sel_row) * COLS_A + AW'(sel_col);
    assign wrap_col = is_nl || (sel_col == LAST_COL);
    assign last_row = (sel_row == LAST_ROW);
    assign adv      = (r_item.action == ACT_PUT_CURSOR) ||
                      ((r_item.action == ACT_PUT_AT) && !bad);
    assign bad_put  = (r_item.action == ACT_PUT_AT) && bad;

    // Cursor advance; stepping past the bottom row stays on it and scrolls.
    always_comb begin
        if (wrap_col) begin
            adv_col = '0;
            adv_row = last_row ? LAST_ROW : sel_row + 1'b1;
        end else begin
            adv_col = sel_col + 1'b1;
            adv_row = sel_row;
        end
    end

    always_comb begin
        n_ccol = r_ccol;
        n_crow = r_crow;
        if (i_cmd.op == OP_EXEC) begin
            if (adv) begin
                n_ccol = adv_col;
                n_crow = adv_row;
            end else if (r_item.action == ACT_CLEAR) begin
                n_ccol = '0;
                n_crow = '0;
            end
        end
    end

    assign src_sum  = {1'b0, r_cnt} + COLS_S;
    assign cnt_last = (i_cmd.op == OP_SCROLL) ? (r_cnt == END_C) : (r_cnt == LAST_C);

    // Memory port steering.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = pos;
        ram_wdata = {at_eff, r_item.char_code};
        ram_raddr = pos;
        case (i_cmd.op)
            OP_EXEC: begin
                ram_we = (adv && !is_nl) || bad_put;
                if (bad_put) begin
                    ram_waddr = LAST_CELL;
                    ram_wdata = {i_error_attr, CH_ERROR};
                end
            end
            OP_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt[AW-1:0];
                ram_wdata = '0;
            end
            OP_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt[AW-1:0];
                ram_wdata = (r_cnt < KEEP_C) ? {i_default_attr, CH_SPACE} : '0;
            end
            OP_SCROLL: begin
                ram_we    = (r_cnt != '0);
                ram_waddr = AW'(r_cnt - 1'b1);
                ram_wdata = (r_cnt <= KEEP_C) ? ram_rdata : '0;
                ram_raddr = (src_sum < CELLS_S) ? AW'(src_sum) : '0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ccol <= '0;
            r_crow <= '0;
            r_cnt  <= '0;
        end else begin
            r_ccol <= n_ccol;
            r_crow <= n_crow;
            if (i_cmd.cnt_run) begin
                r_cnt <= cnt_last ? '0 : r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_item) begin
            r_item <= i_in_item;
        end
        if (i_cmd.load_out) begin
            r_out.cursor_col     <= n_ccol;
            r_out.cursor_row     <= n_crow;
            r_out.read_char      <= ((r_item.action == ACT_READ) && !bad) ?
                                    ram_rdata[BYTE_W-1:0] : '0;
            r_out.read_attr      <= ((r_item.action == ACT_READ) && !bad) ?
                                    ram_rdata[CELL_W-1:BYTE_W] : '0;
            r_out.position_error <= ((r_item.action == ACT_READ) ||
                                     (r_item.action == ACT_PUT_AT)) && bad;
        end
    end

    tccw_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELLS)
    ) u_screen (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_sts.action   = r_item.action;
    assign o_sts.scroll   = (i_cmd.op == OP_EXEC) && adv && wrap_col && last_row;
    assign o_sts.cnt_last = cnt_last;
    assign o_out_item     = r_out;

endmodule

>>> rtl/core/text_console_char_writer.sv
// Text-mode console of ROWS x COLS cells, each holding a character byte (low)
// and an attribute byte (high), plus a text cursor. Each request writes a
// character at the cursor or at a given column and row, reads one cell, or
// clears the screen; every request returns exactly one result with the cursor
// position after the request. A newline character stores nothing and moves the
// cursor to the start of the next row. When the cursor steps past the last
// cell, all rows move up by one, the bottom row is zeroed and the cursor stays
// on the bottom row. An out-of-range position on a write stores 'E' in the
// error attribute in the last cell; on a read it returns zeros. Both report
// position_error. A write with attribute zero uses default_attr. Clear leaves
// spaces in default_attr on all rows but the bottom one, which is zeroed, and
// homes the cursor.
// Sequencing: the screen sits in one single-port-write, single-port-read RAM
// with a registered read, and the block takes no new request until it is
// back in idle. A write is carried out in an execute state and its result
// registered there when the output register is free; a read, and a write
// that finds that register full, pass on to a result state, where a read's
// registered data is taken into the result. A scroll runs a copy pass and a
// clear a clearing pass, each one cell per cycle, before the hand-off. After
// reset the block zeroes the screen in a clearing pass over all ROWS*COLS
// cells (2000 by default) before it accepts its first request; configuration
// writes are taken during that pass. A finished result sits in an output
// register, so the result of one request may wait for the consumer while the
// next request is accepted; a second result that finds the output register
// still full holds the block until the consumer takes the first.
// Registers (APB, 32-bit data): default_attr at 0x0 (reset 15) and
// error_attr at 0x4 (reset 244), low 8 bits used.
module text_console_char_writer #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tccw_pkg::t_in_item  i_in_item,

    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tccw_pkg::t_out_item o_out_item,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    import tccw_pkg::*;

    logic [7:0] r_default_attr;
    logic [7:0] r_error_attr;
    logic       cfg_wr;
    t_cmd       cmd;
    t_sts       sts;

    // Register file: written in the access phase, read combinationally.
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_attr <= DEFAULT_ATTR_RST;
            r_error_attr   <= ERROR_ATTR_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_DEFAULT_ATTR) begin
                r_default_attr <= pwdata[7:0];
            end else begin
                r_error_attr <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_ERROR_ATTR) begin
            prdata = {24'd0, r_error_attr};
        end else begin
            prdata = {24'd0, r_default_attr};
        end
    end

    // The controller sequences each request and the memory sweeps; the
    // datapath holds the cursor, the screen memory and the result register.
    tccw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tccw_dpath #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_in_item     (i_in_item),
        .i_default_attr(r_default_attr),
        .i_error_attr  (r_error_attr),
        .o_sts         (sts),
        .o_out_item    (o_out_item)
    );

endmodule

>>> bench/tb_text_console_char_writer.sv
`timescale 1ns / 100ps

module tb_text_console_char_writer;
    import tccw_pkg::*;

    // Screen geometry. The block runs with these values so the shadow screen
    // below matches its store cell for cell.
    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int CELLS = COLS * ROWS;

    // Byte addresses of the two attribute registers.
    localparam logic [2:0] ADDR_DEFAULT_ATTR = 3'(4 * int'(REG_DEFAULT_ATTR));
    localparam logic [2:0] ADDR_ERROR_ATTR   = 3'(4 * int'(REG_ERROR_ATTR));

    // The slowest request is a scroll or a clear, each of which walks the whole
    // screen, on top of random stalls. Even if every one of the roughly 1900
    // requests took the slow path, the run would stay well under the ceiling.
    localparam int unsigned CYCLE_LIMIT = 20_000_000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          PHASES      = 5;
    localparam int          RANDOM_PER_PHASE = 370;
    localparam int          SETTLE_CYCLES    = 50;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item  = '0;

    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    text_console_char_writer #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Requests waiting to be offered to the block, and the answers that the
    // shadow console has worked out for requests the block already took.
    t_in_item    request_backlog[$];
    t_out_item   console_answers[$];

    // Shadow copy of the console: cells hold the attribute in the high byte
    // and the character in the low byte, exactly like the block's store.
    logic [15:0] shadow_screen[CELLS];
    int unsigned shadow_cursor;
    logic [7:0]  shadow_default_attr;
    logic [7:0]  shadow_error_attr;

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // Set by the stimulus process: burst_mode turns idling off on both sides,
    // hold_request asks the result side for one long stall.
    logic        burst_mode   = 1'b0;
    logic        hold_request = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow console
    // ------------------------------------------------------------------

    function automatic void reset_shadow();
        foreach (shadow_screen[i]) shadow_screen[i] = '0;
        shadow_cursor       = 0;
        shadow_default_attr = DEFAULT_ATTR_RST;
        shadow_error_attr   = ERROR_ATTR_RST;
    endfunction

    // All rows move up by one and the bottom row comes in zeroed.
    function automatic void scroll_shadow();
        for (int i = 0; i < CELLS - COLS; i++) shadow_screen[i] = shadow_screen[i + COLS];
        for (int i = CELLS - COLS; i < CELLS; i++) shadow_screen[i] = '0;
    endfunction

    // Stores one character (or ends the line on a newline) and steps the
    // cursor, scrolling once when it runs off the last cell.
    function automatic void place_char(int unsigned pos, logic [7:0] ch, logic [7:0] attr);
        if (ch == CH_NEWLINE) begin
            pos = (pos / COLS) * COLS + (COLS - 1);
        end else begin
            shadow_screen[pos] = {attr, ch};
        end
        shadow_cursor = pos + 1;
        if (shadow_cursor >= CELLS) begin
            scroll_shadow();
            shadow_cursor -= COLS;
        end
    endfunction

    // Applies one request to the shadow console and returns the answer the
    // block should give for it.
    function automatic t_out_item apply_request(t_in_item req);
        t_out_item   ans;
        logic [7:0]  attr;
        logic        off_screen;
        int unsigned pos;
        ans        = '0;
        attr       = (req.attribute == 8'd0) ? shadow_default_attr : req.attribute;
        off_screen = (int'(req.col) >= COLS) || (int'(req.row) >= ROWS);
        pos        = int'(req.row) * COLS + int'(req.col);
        case (req.action)
            ACT_PUT_CURSOR: begin
                place_char(shadow_cursor, req.char_code, attr);
            end
            ACT_PUT_AT: begin
                if (off_screen) begin
                    // A bad position marks the last cell and leaves the cursor.
                    shadow_screen[CELLS - 1] = {shadow_error_attr, CH_ERROR};
                    ans.position_error = 1'b1;
                end else begin
                    place_char(pos, req.char_code, attr);
                end
            end
            ACT_READ: begin
                if (off_screen) begin
                    ans.position_error = 1'b1;
                end else begin
                    ans.read_char = shadow_screen[pos][7:0];
                    ans.read_attr = shadow_screen[pos][15:8];
                end
            end
            default: begin
                // Clear fills every cell with a space; its last step runs off
                // the end, so one scroll follows and the bottom row is zero.
                foreach (shadow_screen[i]) shadow_screen[i] = {shadow_default_attr, CH_SPACE};
                scroll_shadow();
                shadow_cursor = 0;
            end
        endcase
        ans.cursor_col = 7'(shadow_cursor % COLS);
        ans.cursor_row = 5'(shadow_cursor / COLS);
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: offers the backlog, holding each request until the
    // block takes it. The shadow console is advanced at the accepting edge.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                console_answers.push_back(apply_request(i_in_item));
            end
            if (!i_in_valid || o_in_ready) begin
                if (request_backlog.size() != 0 &&
                    (burst_mode || $urandom_range(99) >= 21)) begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= request_backlog.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compares every result with the oldest answer and
    // drives the result-side ready, including the one long hold-off.
    // ------------------------------------------------------------------

    task automatic report_mismatch(string field, int unsigned want, int unsigned got);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    int  hold_left   = 0;
    logic hold_served = 1'b0;

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (console_answers.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with no request outstanding, actual %h",
                             $time, o_out_item);
                end else begin
                    want = console_answers.pop_front();
                    if (o_out_item.cursor_col != want.cursor_col)
                        report_mismatch("cursor_col", want.cursor_col, o_out_item.cursor_col);
                    if (o_out_item.cursor_row != want.cursor_row)
                        report_mismatch("cursor_row", want.cursor_row, o_out_item.cursor_row);
                    if (o_out_item.read_char != want.read_char)
                        report_mismatch("read_char", want.read_char, o_out_item.read_char);
                    if (o_out_item.read_attr != want.read_attr)
                        report_mismatch("read_attr", want.read_attr, o_out_item.read_attr);
                    if (o_out_item.position_error != want.position_error)
                        report_mismatch("position_error", want.position_error,
                                        o_out_item.position_error);
                end
            end
            // The hold-off is counted here so the sender keeps offering
            // requests while results pile up and the block stalls its input.
            if (hold_request && !hold_served) begin
                hold_left   = HOLD_CYCLES;
                hold_served = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= burst_mode || ($urandom_range(99) >= 21);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("text_console_char_writer regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic void queue_request(logic [1:0] act, logic [7:0] ch, logic [7:0] attr,
                                          int cl, int rw);
        t_in_item req;
        req.action    = act;
        req.char_code = ch;
        req.attribute = attr;
        req.col       = 7'(cl);
        req.row       = 5'(rw);
        request_backlog.push_back(req);
    endfunction

    // Mostly in-range positions with ordinary characters; some positions use
    // the whole field range so bad columns and rows keep turning up. Clears
    // are rare because each one walks the whole screen.
    function automatic t_in_item random_request();
        t_in_item req;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 45)      req.action = ACT_PUT_CURSOR;
        else if (pick < 70) req.action = ACT_PUT_AT;
        else if (pick < 97) req.action = ACT_READ;
        else                req.action = ACT_CLEAR;
        req.char_code = ($urandom_range(99) < 8) ? CH_NEWLINE : 8'($urandom_range(255));
        req.attribute = ($urandom_range(99) < 15) ? 8'd0 : 8'($urandom_range(255));
        req.col = ($urandom_range(99) < 85) ? 7'($urandom_range(COLS - 1))
                                            : 7'($urandom_range(127));
        req.row = ($urandom_range(99) < 85) ? 5'($urandom_range(ROWS - 1))
                                            : 5'($urandom_range(31));
        return req;
    endfunction

    // Setup cycle, then access cycle; pready is always high so the register
    // is written at the edge that ends the access cycle.
    task automatic write_register(logic [2:0] addr, logic [7:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_DEFAULT_ATTR) shadow_default_attr = value;
        else                           shadow_error_attr   = value;
    endtask

    // Every request gives exactly one result, so the block is idle once all
    // requests are taken and all answers have come back.
    task automatic wait_until_drained();
        while (request_backlog.size() != 0 || i_in_valid || console_answers.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        logic [7:0] dflt_setting[PHASES];
        logic [7:0] err_setting[PHASES];

        // Phase 0 keeps the reset values; the others sweep both extremes
        // and a couple of arbitrary values.
        dflt_setting = '{DEFAULT_ATTR_RST, 8'd0,   8'd255, 8'($urandom_range(255)), 8'd1};
        err_setting  = '{ERROR_ATTR_RST,   8'd255, 8'd0,   8'($urandom_range(255)), 8'd128};

        reset_shadow();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                wait_until_drained();
                write_register(ADDR_DEFAULT_ATTR, dflt_setting[phase]);
                write_register(ADDR_ERROR_ATTR, err_setting[phase]);
            end
            burst_mode   <= (phase == 2);
            hold_request <= (phase == 3);

            if (phase == 0) begin
                // Fresh screen reads back zero; default and explicit attributes.
                queue_request(ACT_READ,       8'h00, 8'h00, 0, 0);
                queue_request(ACT_PUT_CURSOR, "A",   8'h00, 0, 0);
                queue_request(ACT_PUT_CURSOR, 8'hFF, 8'hFF, 0, 0);
                queue_request(ACT_PUT_CURSOR, CH_NEWLINE, 8'h00, 0, 0);
                // Last column of a row wraps the cursor to the next row.
                queue_request(ACT_PUT_AT,     8'h00, 8'h01, COLS - 1, 0);
                queue_request(ACT_READ,       8'h00, 8'h00, COLS - 1, 0);
                // Bad write positions mark the last cell and keep the cursor.
                queue_request(ACT_PUT_AT,     "b",   8'h11, COLS, 0);
                queue_request(ACT_PUT_AT,     "c",   8'h22, 127, 31);
                queue_request(ACT_READ,       8'h00, 8'h00, COLS - 1, ROWS - 1);
                // Bad read positions answer zeros with the error flag.
                queue_request(ACT_READ,       8'h00, 8'h00, 0, ROWS);
                queue_request(ACT_READ,       8'h00, 8'h00, 127, 0);
                // Newline at a given position moves to the next row start.
                queue_request(ACT_PUT_AT,     CH_NEWLINE, 8'h00, 5, 3);
                // Writing the very last cell scrolls the screen.
                queue_request(ACT_PUT_AT,     "Z",   8'h7E, COLS - 1, ROWS - 1);
                // Newline on the bottom row scrolls once more.
                queue_request(ACT_PUT_CURSOR, CH_NEWLINE, 8'h00, 0, 0);
                queue_request(ACT_READ,       8'h00, 8'h00, COLS - 1, ROWS - 3);
                queue_request(ACT_PUT_AT,     "x",   8'h80, COLS - 2, ROWS - 1);
                queue_request(ACT_CLEAR,      8'h00, 8'h00, 0, 0);
                queue_request(ACT_READ,       8'h00, 8'h00, 0, 0);
                queue_request(ACT_READ,       8'h00, 8'h00, 0, ROWS - 1);
            end else if (phase == 1) begin
                // Default attribute of zero: attribute zero stores zero.
                queue_request(ACT_PUT_CURSOR, "q",   8'h00, 0, 0);
                queue_request(ACT_PUT_AT,     "w",   8'h00, 10, 10);
                queue_request(ACT_READ,       8'h00, 8'h00, 10, 10);
                queue_request(ACT_PUT_AT,     "e",   8'h00, COLS, ROWS);
                queue_request(ACT_READ,       8'h00, 8'h00, COLS - 1, ROWS - 1);
            end

            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                request_backlog.push_back(random_request());
        end

        wait_until_drained();
        burst_mode   <= 1'b0;
        hold_request <= 1'b0;
        // Give any stray result time to show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("text_console_char_writer regression: pass");
        end else begin
            $display("text_console_char_writer regression: fail");
        end
        $finish;
    end

endmodule
